>>> design/hsvrgb_pkg.sv
`default_nettype none
package hsvrgb_pkg;

	// Hue circle geometry
	localparam logic [10:0] SECTOR_SPAN = 11'd255;
	localparam logic [10:0] HUE_STEPS   = 11'd1530;
	localparam logic [26:0] HUE_ROUND   = 27'd32768;
	localparam logic [7:0]  CHAN_FULL   = 8'hff;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_out_t;

	// Advance strobes for the two channel scaling stages
	typedef struct packed {
		logic adv_s3;
		logic adv_s4;
	} stage_adv_t;

endpackage
`default_nettype wire

>>> design/hsvrgb_chan.sv
`default_nettype none
module hsvrgb_chan
	import hsvrgb_pkg::*;
(
	input  wire        clk,
	input  wire stage_adv_t ctrl,
	input  wire  [7:0] chan,
	input  wire  [7:0] sat,
	input  wire  [7:0] bri,
	output logic [7:0] res
);

	logic [16:0] sat_prod;
	logic [8:0]  sat_sum;
	logic [7:0]  mix_s3;
	logic [7:0]  bri_s3;
	logic [16:0] bri_prod;

	// Apply saturation: blend channel toward white
	always_comb begin
		sat_prod = 17'(chan) * 17'({1'b0, sat} + 9'd1);
		sat_sum  = {1'b0, sat_prod[15:8]} + {1'b0, CHAN_FULL - sat};
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s3) begin
			mix_s3 <= sat_sum[7:0];
			bri_s3 <= bri;
		end
	end

	// Apply brightness, keep the upper byte
	assign bri_prod = 17'(mix_s3) * 17'({1'b0, bri_s3} + 9'd1);

	always_ff @(posedge clk) begin
		if (ctrl.adv_s4) begin
			res <= bri_prod[15:8];
		end
	end

endmodule
`default_nettype wire

>>> design/hsv_to_rgb_converter_unit.sv
`default_nettype none
// An item accepted on pix passes through the stage registers s1, s2, s3 and
// s4 before its result is shown on rgb.
// Throughput: one item per cycle while rgb_stall is low; four register stages, each with its own
// valid bit, so bubbles close up behind a stalled output.
// Reset clears the stage valid bits only; pixel data registers are not reset.
module hsv_to_rgb_converter_unit
	import hsvrgb_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      pix_valid,
	output logic     pix_stall,
	input  wire pix_in_t pix,
	output logic     rgb_valid,
	input  wire      rgb_stall,
	output pix_out_t rgb
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic        rdy1, rdy2, rdy3, rdy4;
	logic [26:0] hue_prod;
	logic [10:0] pos_s1;
	logic [7:0]  sat_s1, bri_s1;
	logic [7:0]  red_c, green_c, blue_c;
	logic [7:0]  red_s2, green_s2, blue_s2;
	logic [7:0]  sat_s2, bri_s2;
	logic [10:0] diff;
	stage_adv_t  ctrl;

	// Per-stage ready: a stage moves when empty or when its successor moves
	assign rdy4 = !vld_s4 || !rgb_stall;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign pix_stall = !rdy1;
	assign ctrl.adv_s3 = rdy3;
	assign ctrl.adv_s4 = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= pix_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	// Scale the replicated hue byte onto 0..1530 with rounding
	assign hue_prod = 27'({pix.hue, pix.hue}) * 27'(HUE_STEPS) + HUE_ROUND;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pos_s1 <= hue_prod[26:16];
			sat_s1 <= pix.saturation;
			bri_s1 <= pix.brightness;
		end
	end

	// Pick the sector ramp; end of circle gives pure red
	always_comb begin
		red_c   = CHAN_FULL;
		green_c = 8'd0;
		blue_c  = 8'd0;
		diff    = 11'd0;
		if (pos_s1 < 11'(2 * SECTOR_SPAN)) begin
			if (pos_s1 < SECTOR_SPAN) begin
				green_c = pos_s1[7:0];
			end else begin
				diff    = 11'(2 * SECTOR_SPAN) - pos_s1;
				red_c   = diff[7:0];
				green_c = CHAN_FULL;
			end
		end else if (pos_s1 < 11'(4 * SECTOR_SPAN)) begin
			red_c = 8'd0;
			if (pos_s1 < 11'(3 * SECTOR_SPAN)) begin
				diff    = pos_s1 - 11'(2 * SECTOR_SPAN);
				green_c = CHAN_FULL;
				blue_c  = diff[7:0];
			end else begin
				diff    = 11'(4 * SECTOR_SPAN) - pos_s1;
				green_c = diff[7:0];
				blue_c  = CHAN_FULL;
			end
		end else if (pos_s1 < HUE_STEPS) begin
			if (pos_s1 < 11'(5 * SECTOR_SPAN)) begin
				diff   = pos_s1 - 11'(4 * SECTOR_SPAN);
				red_c  = diff[7:0];
				blue_c = CHAN_FULL;
			end else begin
				diff   = HUE_STEPS - pos_s1;
				blue_c = diff[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			red_s2   <= red_c;
			green_s2 <= green_c;
			blue_s2  <= blue_c;
			sat_s2   <= sat_s1;
			bri_s2   <= bri_s1;
		end
	end

	// Saturation and brightness, one scaler per channel
	hsvrgb_chan u_red (
		.clk  (clk),
		.ctrl (ctrl),
		.chan (red_s2),
		.sat  (sat_s2),
		.bri  (bri_s2),
		.res  (rgb.red)
	);

	hsvrgb_chan u_green (
		.clk  (clk),
		.ctrl (ctrl),
		.chan (green_s2),
		.sat  (sat_s2),
		.bri  (bri_s2),
		.res  (rgb.green)
	);

	hsvrgb_chan u_blue (
		.clk  (clk),
		.ctrl (ctrl),
		.chan (blue_s2),
		.sat  (sat_s2),
		.bri  (bri_s2),
		.res  (rgb.blue)
	);

	assign rgb_valid = vld_s4;

endmodule
`default_nettype wire

>>> tb/sv/tb_hsv_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
module tb_hsv_to_rgb_converter_unit;
	import hsvrgb_pkg::*;

	localparam int RAMP_SPAN    = 255;
	localparam int HUE_CIRCLE   = 1530;
	localparam int RANDOM_PIX   = 1800;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int CALM_FROM    = 900;
	localparam int CALM_TO      = 1150;
	localparam int DRAIN_AT     = 1400;
	localparam int TAIL_CYCLES  = 12;

	typedef struct {
		pix_in_t px;
		bit      drain;
	} pix_job_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     pix_valid = 1'b0;
	logic     pix_stall;
	pix_in_t  pix = '0;
	logic     rgb_valid;
	logic     rgb_stall = 1'b0;
	pix_out_t rgb;

	pix_job_t pix_backlog[$];
	pix_out_t rgb_pending[$];
	int       pix_taken_cnt = 0;
	int       fail_cnt = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	bit       pix_took = 1'b0;
	bit       calm;

	hsv_to_rgb_converter_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	always #2 clk = ~clk;

	// no idling on either side inside this window of accepted items
	assign calm = (pix_taken_cnt >= CALM_FROM) && (pix_taken_cnt < CALM_TO);

	// apply saturation and brightness to one channel level
	function automatic logic [7:0] shade(int level, int sat, int val);
		int t;
		t = (((level * (sat + 1)) >> 8) + 255 - sat) * (val + 1);
		return t[15:8];
	endfunction

	// expected color for one pixel
	function automatic pix_out_t hsv_to_rgb(pix_in_t px);
		logic [15:0] h16;
		int          pos;
		int          r, g, b;
		pix_out_t    res;
		h16 = {px.hue, px.hue};
		pos = (int'(h16) * HUE_CIRCLE + 32768) >> 16;
		if (pos < 2 * RAMP_SPAN) begin
			b = 0;
			if (pos < RAMP_SPAN) begin
				r = 255;
				g = pos;
			end else begin
				r = 2 * RAMP_SPAN - pos;
				g = 255;
			end
		end else if (pos < 4 * RAMP_SPAN) begin
			r = 0;
			if (pos < 3 * RAMP_SPAN) begin
				g = 255;
				b = pos - 2 * RAMP_SPAN;
			end else begin
				g = 4 * RAMP_SPAN - pos;
				b = 255;
			end
		end else if (pos < HUE_CIRCLE) begin
			g = 0;
			if (pos < 5 * RAMP_SPAN) begin
				r = pos - 4 * RAMP_SPAN;
				b = 255;
			end else begin
				r = 255;
				b = HUE_CIRCLE - pos;
			end
		end else begin
			// end of the hue circle wraps to pure red
			r = 255;
			g = 0;
			b = 0;
		end
		res.red   = shade(r, px.saturation, px.brightness);
		res.green = shade(g, px.saturation, px.brightness);
		res.blue  = shade(b, px.saturation, px.brightness);
		return res;
	endfunction

	task automatic flag_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_cnt++;
	endtask

	task automatic queue_pix(logic [7:0] h, logic [7:0] s, logic [7:0] v);
		pix_job_t job;
		job.px.hue        = h;
		job.px.saturation = s;
		job.px.brightness = v;
		job.drain         = 1'b0;
		pix_backlog.push_back(job);
	endtask

	// record accepted pixels and their expected colors
	always @(posedge clk) begin
		pix_took = pix_valid && !pix_stall;
		if (pix_took) begin
			rgb_pending.push_back(hsv_to_rgb(pix));
			pix_taken_cnt++;
		end
	end

	// offer the next pixel once the current one is taken
	always @(negedge clk) begin : drive_pix
		pix_job_t job;
		if (arst_n && (!pix_valid || pix_took)) begin
			if (pix_backlog.size() == 0) begin
				pix_valid <= 1'b0;
			end else if (pix_backlog[0].drain) begin
				// hold off until every outstanding color has come back
				pix_valid <= 1'b0;
				if (rgb_pending.size() == 0)
					job = pix_backlog.pop_front();
			end else if (!calm && $urandom_range(99) < 27) begin
				pix_valid <= 1'b0;
			end else begin
				job = pix_backlog.pop_front();
				pix       <= job.px;
				pix_valid <= 1'b1;
			end
		end
	end

	// stall the output at random, with one long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rgb_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && pix_taken_cnt >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			rgb_stall <= 1'b1;
		end else begin
			rgb_stall <= !calm && ($urandom_range(99) < 27);
		end
	end

	// check each accepted color against the oldest expectation
	always @(posedge clk) begin : check_rgb
		pix_out_t want;
		if (arst_n && rgb_valid && !rgb_stall) begin
			if (rgb_pending.size() == 0) begin
				flag_mismatch($sformatf("color %h with no pixel waiting", rgb));
			end else begin
				want = rgb_pending.pop_front();
				if (rgb.red !== want.red)
					flag_mismatch($sformatf("red %h, want %h", rgb.red, want.red));
				if (rgb.green !== want.green)
					flag_mismatch($sformatf("green %h, want %h", rgb.green, want.green));
				if (rgb.blue !== want.blue)
					flag_mismatch($sformatf("blue %h, want %h", rgb.blue, want.blue));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		pix_job_t pause;
		int       k;
		// hue sector edges and wrap at full saturation and brightness, then saturation and brightness corners
		queue_pix(8'd0,   8'd255, 8'd255);
		queue_pix(8'd255, 8'd255, 8'd255);
		queue_pix(8'd254, 8'd255, 8'd255);
		queue_pix(8'd1,   8'd255, 8'd255);
		queue_pix(8'd42,  8'd255, 8'd255);
		queue_pix(8'd43,  8'd255, 8'd255);
		queue_pix(8'd85,  8'd255, 8'd255);
		queue_pix(8'd127, 8'd255, 8'd255);
		queue_pix(8'd128, 8'd255, 8'd255);
		queue_pix(8'd170, 8'd255, 8'd255);
		queue_pix(8'd213, 8'd255, 8'd255);
		queue_pix(8'd0,   8'd0,   8'd0);
		queue_pix(8'd255, 8'd0,   8'd255);
		queue_pix(8'd255, 8'd255, 8'd0);
		queue_pix(8'd100, 8'd0,   8'd255);
		queue_pix(8'd200, 8'd128, 8'd128);
		queue_pix(8'd255, 8'd1,   8'd1);
		queue_pix(8'd64,  8'd254, 8'd254);
		queue_pix(8'd191, 8'd127, 8'd200);
		queue_pix(8'd21,  8'd255, 8'd1);
		// random pixels, some pinned to the edges of saturation and brightness
		for (k = 0; k < RANDOM_PIX; k++) begin
			if (k == DRAIN_AT) begin
				pause.px    = '0;
				pause.drain = 1'b1;
				pix_backlog.push_back(pause);
			end
			case ($urandom_range(7))
				0: queue_pix(8'($urandom), 8'd255, 8'd255);
				1: queue_pix(8'($urandom), $urandom_range(1) ? 8'd0 : 8'd255,
					8'($urandom));
				2: queue_pix(8'($urandom), 8'($urandom),
					$urandom_range(1) ? 8'd0 : 8'd255);
				3: queue_pix($urandom_range(1) ? 8'd255 : 8'd0, 8'($urandom),
					8'($urandom));
				default: queue_pix(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain everything, then allow for the pipeline depth
		while (pix_backlog.size() != 0 || pix_valid || rgb_pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_cnt == 0 && rgb_pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
